// File: hdl/ctr_pkg.sv
package ctr_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_BRIGHTNESS  = 3'd0,
    CFG_CONTRAST    = 3'd1,
    CFG_HIGHLIGHTS  = 3'd2,
    CFG_SHADOWS     = 3'd3,
    CFG_TEMPERATURE = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS     = 8;

  // Q16 gain or level, 1.0 = 65536.
  typedef logic [16:0] q16_t;

  localparam q16_t ONE_Q16 = 17'd65536;

  // Contrast comes out of reset at 100 percent.
  localparam logic [CFG_BITS-1:0] CONTRAST_RST = 8'd100;

  // Reciprocals for exact floor division by constants.
  // ceil(2^26 / 25): exact for dividends below 2^22.
  localparam logic [21:0] RECIP_25  = 22'd2684355;
  // ceil(2^34 / 625): exact for dividends below 2^24.
  localparam logic [24:0] RECIP_625 = 25'd27487791;

  // Half of 10000, already divided by 16 (the power-of-two part of 10000).
  localparam logic [23:0] TINT_BIAS = 24'd312;

endpackage

// File: hdl/color_tone_ramp.sv
// Tone ramp: every input word carries one level and yields one output word with the red,
// green and blue ramp entries for that level, each saturated to 0..2^OUT_BITS-1. The
// datapath is a ten-stage register pipeline (level scaling, tint gain, contrast, offsets,
// highlight gain, shadow lift, clamp, output scaling), so one word is accepted every clock
// while the output side does not stall. Stalls back up stage by stage, so empty stages are
// filled before in_tready drops. Register writes on the cfg_ port take effect for every
// word accepted after the write; they are meant to be made while no word is in flight.
module color_tone_ramp #(
  parameter int IN_BITS  = 8,
  parameter int OUT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input words.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((IN_BITS + 7) / 8) * 8 - 1:0]   in_tdata,   // level
  // Result words.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((3 * OUT_BITS + 7) / 8) * 8 - 1:0] out_tdata, // red_out, green_out, blue_out
  // Register writes.
  input  logic                                   cfg_wen,
  input  logic [ctr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [ctr_pkg::CFG_BITS-1:0]           cfg_wdata
);

  localparam int NST = 10;                   // pipeline stages
  localparam int NB  = IN_BITS + 16;         // width of the scaled level numerator
  localparam int SH  = NB + IN_BITS;         // reciprocal shift
  localparam int SW  = 17 + OUT_BITS;        // output scaling width
  localparam longint unsigned IN_MAX  = (64'd1 << IN_BITS) - 64'd1;
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + IN_MAX - 64'd1) / IN_MAX;
  localparam longint unsigned HALF_L  = (IN_MAX - 64'd1) / 2;
  localparam logic [NB:0]   RECIP    = RECIP_L[NB:0];
  localparam logic [NB-1:0] HALF_MAX = HALF_L[NB-1:0];

  // round(p * 65536 / 200), half away from zero.
  function automatic logic signed [16:0] pct_half(input logic [7:0] p);
    logic [7:0]  mag;
    logic [20:0] m;
    logic [42:0] prod;
    logic [16:0] q;
    mag  = p[7] ? (~p + 8'd1) : p;
    m    = {mag, 13'd0} + 21'd12;
    prod = m * ctr_pkg::RECIP_25;
    q    = prod[42:26];
    return p[7] ? -$signed(q) : $signed(q);
  endfunction

  // round(c * 65536 / 100) for an unsigned percentage.
  function automatic logic [17:0] pct_full(input logic [7:0] c);
    logic [21:0] m;
    logic [43:0] prod;
    m    = {c, 14'd0} + 22'd12;
    prod = m * ctr_pkg::RECIP_25;
    return prod[43:26];
  endfunction

  // Floor of a tint numerator (already divided by 16) by 625.
  function automatic logic [14:0] tint_div(input logic [23:0] m);
    logic [48:0] prod;
    prod = m * ctr_pkg::RECIP_625;
    return prod[48:34];
  endfunction

  // Raw registers.
  logic [7:0] bri_cfg_r, con_cfg_r, hil_cfg_r, sha_cfg_r, tmp_cfg_r;

  // Derived Q16 coefficients.
  ctr_pkg::q16_t        tint_r [3];
  logic [17:0]          con_r;
  logic signed [16:0]   coff_r;
  logic signed [16:0]   bri_r;
  ctr_pkg::q16_t        hil_r;
  logic signed [16:0]   sha_r;
  ctr_pkg::q16_t        shc_r;

  ctr_pkg::q16_t        tint_nxt [3];
  logic signed [16:0]   coff_nxt;
  ctr_pkg::q16_t        hil_nxt;
  ctr_pkg::q16_t        shc_nxt;
  logic [7:0]           tmag;
  logic [14:0]          d18, d04;
  logic signed [18:0]   con_rest;
  logic signed [18:0]   con_rest_rnd;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bri_cfg_r <= '0;
      con_cfg_r <= ctr_pkg::CONTRAST_RST;
      hil_cfg_r <= '0;
      sha_cfg_r <= '0;
      tmp_cfg_r <= '0;
    end else if (cfg_wen) begin
      case (ctr_pkg::cfg_idx_t'(cfg_index))
        ctr_pkg::CFG_BRIGHTNESS:  bri_cfg_r <= cfg_wdata;
        ctr_pkg::CFG_CONTRAST:    con_cfg_r <= cfg_wdata;
        ctr_pkg::CFG_HIGHLIGHTS:  hil_cfg_r <= cfg_wdata;
        ctr_pkg::CFG_SHADOWS:     sha_cfg_r <= cfg_wdata;
        ctr_pkg::CFG_TEMPERATURE: tmp_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coefficients from the raw registers.
  always_comb begin
    tmag = tmp_cfg_r[7] ? (~tmp_cfg_r + 8'd1) : tmp_cfg_r;
    d18  = tint_div({tmag, 16'd0} + {3'b000, tmag, 13'd0} + ctr_pkg::TINT_BIAS);
    d04  = tint_div({2'b00, tmag, 14'd0} + ctr_pkg::TINT_BIAS);
    if (tmp_cfg_r[7]) begin
      tint_nxt[0] = ctr_pkg::ONE_Q16 - {2'b00, d18};
      tint_nxt[1] = ctr_pkg::ONE_Q16 - {2'b00, d04};
      tint_nxt[2] = ctr_pkg::ONE_Q16 + {2'b00, d18};
    end else begin
      tint_nxt[0] = ctr_pkg::ONE_Q16 + {2'b00, d18};
      tint_nxt[1] = ctr_pkg::ONE_Q16 + {2'b00, d04};
      tint_nxt[2] = ctr_pkg::ONE_Q16 - {2'b00, d18};
    end
    hil_nxt = 17'(18'sd65536 + 18'(pct_half(hil_cfg_r)));
    shc_nxt = 17'(18'sd65536 - 18'(pct_half(sha_cfg_r)));
    // Contrast pivot offset: (1 - C) / 2, rounded half away from zero.
    con_rest     = $signed({2'b00, ctr_pkg::ONE_Q16}) - $signed({1'b0, con_r});
    con_rest_rnd = con_rest + (con_rest[18] ? 19'sd0 : 19'sd1);
    coff_nxt     = con_rest_rnd[17:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        tint_r[c] <= ctr_pkg::ONE_Q16;
      end
      con_r  <= {1'b0, ctr_pkg::ONE_Q16};
      coff_r <= '0;
      bri_r  <= '0;
      hil_r  <= ctr_pkg::ONE_Q16;
      sha_r  <= '0;
      shc_r  <= ctr_pkg::ONE_Q16;
    end else begin
      for (int c = 0; c < 3; c++) begin
        tint_r[c] <= tint_nxt[c];
      end
      con_r  <= pct_full(con_cfg_r);
      coff_r <= coff_nxt;
      bri_r  <= pct_half(bri_cfg_r);
      hil_r  <= hil_nxt;
      sha_r  <= pct_half(sha_cfg_r);
      shc_r  <= shc_nxt;
    end
  end

  // Pipeline flow control: a stage loads when it is empty or the next one moves.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = ~vld_r[NST-1] | out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k - 1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NST-1];

  // Stage data.
  ctr_pkg::q16_t        v_r;
  logic [33:0]          pt_r  [3];
  ctr_pkg::q16_t        vt_r  [3];
  logic [34:0]          pc_r  [3];
  logic signed [19:0]   x1_r  [3];
  logic signed [37:0]   ph_r  [3];
  logic signed [19:0]   x2_r  [3];
  logic signed [37:0]   ps_r  [3];
  ctr_pkg::q16_t        x3_r  [3];
  logic [OUT_BITS-1:0]  out_r [3];

  logic [NB-1:0]        lvl_num;
  logic [2*NB:0]        lvl_prod;
  ctr_pkg::q16_t        v_nxt;
  logic [33:0]          pt_rnd [3];
  logic [34:0]          pc_rnd [3];
  logic signed [19:0]   x1_nxt [3];
  logic signed [37:0]   ph_rnd [3];
  logic signed [37:0]   ps_rnd [3];
  logic signed [21:0]   x3_pre [3];
  ctr_pkg::q16_t        x3_nxt [3];
  logic [SW-1:0]        scl    [3];

  always_comb begin
    // Level to Q16: round(level * 65536 / full scale) by reciprocal multiply.
    lvl_num  = {in_tdata[IN_BITS-1:0], 16'd0} + HALF_MAX;
    lvl_prod = lvl_num * RECIP;
    v_nxt    = lvl_prod[SH +: 17];
    for (int c = 0; c < 3; c++) begin
      pt_rnd[c] = pt_r[c] + 34'd32768;
      pc_rnd[c] = pc_r[c] + 35'd32768;
      // Contrast result plus pivot offset plus brightness.
      x1_nxt[c] = $signed({1'b0, pc_rnd[c][34:16]}) + 20'(coff_r) + 20'(bri_r);
      // Signed products round half away from zero.
      ph_rnd[c] = ph_r[c] + (ph_r[c][37] ? 38'sd32767 : 38'sd32768);
      ps_rnd[c] = ps_r[c] + (ps_r[c][37] ? 38'sd32767 : 38'sd32768);
      x3_pre[c] = $signed(ps_rnd[c][37:16]) + 22'(sha_r);
      if (x3_pre[c][21]) begin
        x3_nxt[c] = '0;
      end else if (x3_pre[c] > 22'sd65536) begin
        x3_nxt[c] = ctr_pkg::ONE_Q16;
      end else begin
        x3_nxt[c] = x3_pre[c][16:0];
      end
      // Scale by 2^OUT_BITS - 1 as a shift and subtract, then drop the fraction.
      scl[c] = {x3_r[c], {OUT_BITS{1'b0}}} - SW'(x3_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v_r <= v_nxt;
    end
    for (int c = 0; c < 3; c++) begin
      if (en[1]) pt_r[c]  <= v_r * tint_r[c];
      if (en[2]) vt_r[c]  <= pt_rnd[c][32:16];
      if (en[3]) pc_r[c]  <= con_r * vt_r[c];
      if (en[4]) x1_r[c]  <= x1_nxt[c];
      if (en[5]) ph_r[c]  <= x1_r[c] * $signed({1'b0, hil_r});
      if (en[6]) x2_r[c]  <= ph_rnd[c][35:16];
      if (en[7]) ps_r[c]  <= x2_r[c] * $signed({1'b0, shc_r});
      if (en[8]) x3_r[c]  <= x3_nxt[c];
      if (en[9]) out_r[c] <= scl[c][16 +: OUT_BITS];
    end
  end

  // Output word packing, red in the lowest bits.
  always_comb begin
    out_tdata = '0;
    out_tdata[0 +: OUT_BITS]            = out_r[0];
    out_tdata[OUT_BITS +: OUT_BITS]     = out_r[1];
    out_tdata[2 * OUT_BITS +: OUT_BITS] = out_r[2];
  end

endmodule

// File: tb/color_tone_ramp_tb.sv
module color_tone_ramp_tb;

  localparam int IN_BITS      = 8;
  localparam int OUT_BITS     = 16;
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W        = ((3 * OUT_BITS + 7) / 8) * 8;
  localparam int PIPE_DEPTH   = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 450;
  localparam int CFG_BITS     = ctr_pkg::CFG_BITS;
  localparam int CFG_IDX_BITS = ctr_pkg::CFG_IDX_BITS;

  localparam longint Q16_ONE = 65536;
  localparam longint IN_MAX  = (longint'(1) << IN_BITS) - 1;
  localparam longint OUT_MAX = (longint'(1) << OUT_BITS) - 1;

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } ramp_entry_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_W-1:0]         in_tdata;   // level
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_W-1:0]        out_tdata;  // red_out, green_out, blue_out
  logic                    cfg_wen;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  // Local copy of the tone registers, as they come out of reset.
  logic [CFG_BITS-1:0] brightness_reg  = '0;
  logic [CFG_BITS-1:0] contrast_reg    = ctr_pkg::CONTRAST_RST;
  logic [CFG_BITS-1:0] highlights_reg  = '0;
  logic [CFG_BITS-1:0] shadows_reg     = '0;
  logic [CFG_BITS-1:0] temperature_reg = '0;

  ramp_entry_t pending_ramps[$];
  int          fail_count  = 0;
  int          idle_cycles = 0;
  int          ready_hold  = 0;
  bit          no_gaps     = 1'b0;

  color_tone_ramp #(
    .IN_BITS (IN_BITS),
    .OUT_BITS(OUT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Division rounded half away from zero; the divisor is positive.
  function automatic longint div_round(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return div_round(a * b, Q16_ONE);
  endfunction

  function automatic longint pct_signed(logic [CFG_BITS-1:0] r);
    return longint'($signed(r));
  endfunction

  // One channel: tint, contrast about mid level, offset, highlight gain, shadow lift, clamp.
  function automatic logic [OUT_BITS-1:0] tone_channel(longint v, longint tint, longint bri,
                                                       longint con, longint hil, longint sha);
    longint              x;
    logic [OUT_BITS-1:0] scaled;
    x = q_mul(con, q_mul(v, tint)) + div_round(Q16_ONE - con, 2) + bri;
    x = q_mul(x, hil);
    x = q_mul(x, Q16_ONE - sha) + sha;
    if (x < 0) begin
      x = 0;
    end
    if (x > Q16_ONE) begin
      x = Q16_ONE;
    end
    scaled = OUT_BITS'((x * OUT_MAX) / Q16_ONE);
    return scaled;
  endfunction

  // Red, green and blue ramp entries for one level under the current registers.
  function automatic ramp_entry_t ramp_entry_for(logic [IN_BITS-1:0] level);
    longint      v, t, bri, con, hil, sha, d_warm, d_green;
    ramp_entry_t e;
    v       = div_round(longint'(level) * Q16_ONE, IN_MAX);
    t       = pct_signed(temperature_reg);
    bri     = div_round(pct_signed(brightness_reg) * Q16_ONE, 200);
    con     = div_round(longint'(contrast_reg) * Q16_ONE, 100);
    hil     = Q16_ONE + div_round(pct_signed(highlights_reg) * Q16_ONE, 200);
    sha     = div_round(pct_signed(shadows_reg) * Q16_ONE, 200);
    d_warm  = div_round(t * 1179648, 10000);
    d_green = div_round(t * 262144, 10000);
    e.red   = tone_channel(v, Q16_ONE + d_warm, bri, con, hil, sha);
    e.green = tone_channel(v, Q16_ONE + d_green, bri, con, hil, sha);
    e.blue  = tone_channel(v, Q16_ONE - d_warm, bri, con, hil, sha);
    return e;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // A register value: mostly in range, sometimes an end of the range, sometimes any byte.
  function automatic logic [CFG_BITS-1:0] pick_pct(int lo, int hi);
    case ($urandom_range(0, 9))
      0: begin
        return CFG_BITS'(lo);
      end
      1: begin
        return CFG_BITS'(hi);
      end
      2: begin
        return CFG_BITS'($urandom);
      end
      default: begin
        return CFG_BITS'(lo + int'($urandom_range(0, hi - lo)));
      end
    endcase
  endfunction

  // Register write; the local copy follows, unknown indexes leave it alone.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      ctr_pkg::CFG_BRIGHTNESS: begin
        brightness_reg = value;
      end
      ctr_pkg::CFG_CONTRAST: begin
        contrast_reg = value;
      end
      ctr_pkg::CFG_HIGHLIGHTS: begin
        highlights_reg = value;
      end
      ctr_pkg::CFG_SHADOWS: begin
        shadows_reg = value;
      end
      ctr_pkg::CFG_TEMPERATURE: begin
        temperature_reg = value;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_tone(input int bri, input int con, input int hil, input int sha,
                          input int temp);
    write_reg(ctr_pkg::CFG_BRIGHTNESS, CFG_BITS'(bri));
    write_reg(ctr_pkg::CFG_CONTRAST, CFG_BITS'(con));
    write_reg(ctr_pkg::CFG_HIGHLIGHTS, CFG_BITS'(hil));
    write_reg(ctr_pkg::CFG_SHADOWS, CFG_BITS'(sha));
    write_reg(ctr_pkg::CFG_TEMPERATURE, CFG_BITS'(temp));
  endtask

  // Offers one level word, waits for it to be taken and records its ramp entry.
  task automatic send_level(input logic [IN_BITS-1:0] level);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(level);
    do @(posedge clk); while (!in_tready);
    pending_ramps.push_back(ramp_entry_for(level));
  endtask

  // Stops sending and waits until every result word is back and the pipeline is empty.
  task automatic wait_until_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_ramps.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd128);
    send_level(8'h55);
    send_level(8'hAA);
    send_level(8'd1);
    wait_until_idle();
  endtask

  // Ends of every range and raw out-of-range bytes, sent back to back.
  task automatic test_register_extremes();
    no_gaps = 1'b1;
    set_tone(100, 200, 100, 100, 100);
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd128);
    wait_until_idle();
    set_tone(-100, 0, -100, -100, -100);
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd128);
    wait_until_idle();
    set_tone(-128, 255, 127, -128, 127);
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd128);
    wait_until_idle();
    set_tone(127, 0, -128, 127, -128);
    send_level(8'd0);
    send_level(8'd255);
    send_level(8'd128);
    wait_until_idle();
    no_gaps = 1'b0;
  endtask

  // Writes to indexes past the last register must not change anything.
  task automatic test_unknown_index();
    set_tone(30, 150, -20, 40, 60);
    for (int i = ctr_pkg::CFG_TEMPERATURE + 1; i < 2 ** CFG_IDX_BITS; i++) begin
      write_reg(CFG_IDX_BITS'(i), CFG_BITS'($urandom));
    end
    send_level(8'd0);
    send_level(8'd200);
    wait_until_idle();
  endtask

  // Random tone settings, each followed by a burst of random levels.
  task automatic test_random_tones();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      set_tone(pick_pct(-100, 100), pick_pct(0, 200), pick_pct(-100, 100),
               pick_pct(-100, 100), pick_pct(-100, 100));
      no_gaps = ($urandom_range(0, 4) == 0);
      burst   = $urandom_range(15, 50);
      if (burst > RANDOM_WORDS - sent) begin
        burst = RANDOM_WORDS - sent;
      end
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_level($urandom_range(0, 1) ? IN_BITS'(IN_MAX) : '0);
        end else begin
          send_level(IN_BITS'($urandom));
        end
        sent++;
        // Now and then the sender holds off until the pipeline has emptied.
        if (i == burst / 2 && $urandom_range(0, 2) == 0) begin
          wait_until_idle();
        end
      end
      wait_until_idle();
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stalls, none while back-to-back traffic is wanted.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_tready <= 1'b0;
        ready_hold--;
      end else begin
        out_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 2) == 0) begin
          ready_hold = pick_gap();
        end
      end
    end
  end

  // Each result word is compared with the oldest recorded ramp entry.
  always @(posedge clk) begin : check_ramp
    ramp_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_ramps.size() == 0) begin
        $error("result word with none expected: %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_ramps.pop_front();
        if (out_tdata[OUT_BITS-1:0] !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, out_tdata[OUT_BITS-1:0]);
          fail_count++;
        end
        if (out_tdata[2*OUT_BITS-1:OUT_BITS] !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green,
                 out_tdata[2*OUT_BITS-1:OUT_BITS]);
          fail_count++;
        end
        if (out_tdata[3*OUT_BITS-1:2*OUT_BITS] !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue,
                 out_tdata[3*OUT_BITS-1:2*OUT_BITS]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_unknown_index();
    test_random_tones();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
